### sv/rrfc_pkg.sv
// ----------------------------------------------------------------------------
// rrfc_pkg
// Types, codes and constants shared by the receive ring frame checker.
// ----------------------------------------------------------------------------
package rrfc_pkg;

    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_RING_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RING_STOP  = CFG_IDX_W'(1);

    localparam logic [7:0] RING_START_RST = 8'd76;
    localparam logic [7:0] RING_STOP_RST  = 8'd128;
    localparam logic [7:0] BOUNDARY_RST   = RING_STOP_RST - 8'd1;

    localparam logic [15:0] MIN_FRAME_LEN  = 16'd60;
    localparam logic [15:0] MAX_FRAME_LEN  = 16'd1518;
    localparam logic [15:0] HDR_BYTES      = 16'd4;
    localparam logic [7:0]  STATUS_MASK    = 8'h0F;
    localparam logic [7:0]  STATUS_OK      = 8'h01;
    localparam int          STATUS_OVR_BIT = 3;

    typedef enum logic [2:0] {
        ACT_EMPTY      = 3'd0,
        ACT_ACCEPT     = 3'd1,
        ACT_BAD_LINK   = 3'd2,
        ACT_BAD_LEN    = 3'd3,
        ACT_BAD_STATUS = 3'd4
    } t_action;

    typedef struct packed {
        logic [7:0] ring_start_page;
        logic [7:0] ring_stop_page;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  cur_page;
        logic [7:0]  hdr_status;
        logic [7:0]  hdr_next;
        logic [15:0] hdr_count;
    } t_rx_item;

    typedef struct packed {
        t_action     action;
        logic [7:0]  frame_page;
        logic [15:0] payload_addr;
        logic [15:0] payload_len;
        logic [7:0]  new_boundary;
        logic [7:0]  fetch_page;
        logic [31:0] err_total;
        logic [31:0] packet_total;
        logic [31:0] byte_total;
        logic [31:0] overrun_total;
    } t_result;

    // page after a boundary, wrapped into the ring
    function automatic logic [7:0] page_after(input logic [7:0] bnd, input t_cfg cfg);
        logic [8:0] p;
        p = {1'b0, bnd} + 9'd1;
        return (p >= {1'b0, cfg.ring_stop_page}) ? cfg.ring_start_page : p[7:0];
    endfunction

endpackage

### sv/rrfc_ifs.sv
// ----------------------------------------------------------------------------
// rrfc_ifs
// Handshake channels of the receive ring frame checker.
// ----------------------------------------------------------------------------
interface rrfc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  cur_page;
    logic [7:0]  hdr_status;
    logic [7:0]  hdr_next;
    logic [15:0] hdr_count;

    modport source (output valid, cur_page, hdr_status, hdr_next, hdr_count,
                    input ready);
    modport sink   (input valid, cur_page, hdr_status, hdr_next, hdr_count,
                    output ready);
endinterface

interface rrfc_out_if;
    logic              valid;
    logic              ready;
    rrfc_pkg::t_action action;
    logic [7:0]        frame_page;
    logic [15:0]       payload_addr;
    logic [15:0]       payload_len;
    logic [7:0]        new_boundary;
    logic [7:0]        fetch_page;
    logic [31:0]       err_total;
    logic [31:0]       packet_total;
    logic [31:0]       byte_total;
    logic [31:0]       overrun_total;

    modport source (output valid, action, frame_page, payload_addr, payload_len,
                    new_boundary, fetch_page, err_total, packet_total, byte_total,
                    overrun_total, input ready);
    modport sink   (input valid, action, frame_page, payload_addr, payload_len,
                    new_boundary, fetch_page, err_total, packet_total, byte_total,
                    overrun_total, output ready);
endinterface

interface rrfc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rrfc_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/rrfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// rrfc_cfg_regs
// Ring start and stop page registers behind the configuration channel.
// ----------------------------------------------------------------------------
module rrfc_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rrfc_cfg_if.sink       i_cfg,
    output rrfc_pkg::t_cfg o_cfg
);
    import rrfc_pkg::*;

    logic [7:0] r_start;
    logic [7:0] r_stop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= RING_START_RST;
            r_stop  <= RING_STOP_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_RING_START: r_start <= i_cfg.data;
                REG_RING_STOP:  r_stop  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_cfg.ring_start_page = r_start;
    assign o_cfg.ring_stop_page  = r_stop;

endmodule

### sv/rrfc_unload.sv
// ----------------------------------------------------------------------------
// rrfc_unload
// Boundary and statistics registers with the per-frame header check.
// ----------------------------------------------------------------------------
module rrfc_unload (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrfc_pkg::t_cfg      i_cfg,
    input  rrfc_pkg::t_rx_item  i_item,
    input  logic                i_step,
    output rrfc_pkg::t_result   o_result
);
    import rrfc_pkg::*;

    logic [7:0]  r_boundary, n_boundary;
    logic [31:0] r_err_cnt, n_err_cnt;
    logic [31:0] r_pkt_cnt, n_pkt_cnt;
    logic [31:0] r_byte_cnt, n_byte_cnt;
    logic [31:0] r_ovr_cnt, n_ovr_cnt;

    logic [7:0]         w_frame;
    logic [15:0]        w_len;
    logic signed [10:0] w_nxt;
    logic signed [10:0] w_nxt1;
    logic signed [10:0] w_size;
    logic signed [10:0] w_link;
    logic               w_link_ok;
    logic               w_len_ok;
    logic               w_status_ok;
    t_action            w_action;

    assign w_frame = page_after(r_boundary, i_cfg);
    assign w_len   = i_item.hdr_count - HDR_BYTES;
    assign w_nxt   = $signed({3'b000, w_frame}) + $signed({3'b000, i_item.hdr_count[15:8]})
                   + 11'sd1;
    assign w_nxt1  = w_nxt + 11'sd1;
    assign w_size  = $signed({3'b000, i_cfg.ring_stop_page})
                   - $signed({3'b000, i_cfg.ring_start_page});
    assign w_link  = $signed({3'b000, i_item.hdr_next});

    assign w_link_ok = (w_link == w_nxt) || (w_link == w_nxt1)
                    || (w_link == w_nxt - w_size) || (w_link == w_nxt1 - w_size);
    assign w_len_ok    = (w_len >= MIN_FRAME_LEN) && (w_len <= MAX_FRAME_LEN);
    assign w_status_ok = (i_item.hdr_status & STATUS_MASK) == STATUS_OK;

    always_comb begin
        n_boundary = r_boundary;
        n_err_cnt  = r_err_cnt;
        n_pkt_cnt  = r_pkt_cnt;
        n_byte_cnt = r_byte_cnt;
        n_ovr_cnt  = r_ovr_cnt;
        if (w_frame == i_item.cur_page) begin
            w_action = ACT_EMPTY;
        end else if (!w_link_ok) begin
            w_action   = ACT_BAD_LINK;
            n_err_cnt  = r_err_cnt + 32'd1;
            n_boundary = i_item.cur_page - 8'd1;
        end else begin
            n_boundary = i_item.hdr_next - 8'd1;
            if (!w_len_ok) begin
                w_action  = ACT_BAD_LEN;
                n_err_cnt = r_err_cnt + 32'd1;
            end else if (w_status_ok) begin
                w_action   = ACT_ACCEPT;
                n_pkt_cnt  = r_pkt_cnt + 32'd1;
                n_byte_cnt = r_byte_cnt + {16'd0, w_len};
            end else begin
                w_action = ACT_BAD_STATUS;
                if (i_item.hdr_status[STATUS_OVR_BIT]) begin
                    n_ovr_cnt = r_ovr_cnt + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boundary <= BOUNDARY_RST;
            r_err_cnt  <= '0;
            r_pkt_cnt  <= '0;
            r_byte_cnt <= '0;
            r_ovr_cnt  <= '0;
        end else if (i_step) begin
            r_boundary <= n_boundary;
            r_err_cnt  <= n_err_cnt;
            r_pkt_cnt  <= n_pkt_cnt;
            r_byte_cnt <= n_byte_cnt;
            r_ovr_cnt  <= n_ovr_cnt;
        end
    end

    always_comb begin
        o_result.action        = w_action;
        o_result.frame_page    = w_frame;
        o_result.payload_addr  = (w_action == ACT_EMPTY) ? 16'd0 : {w_frame, 8'h00} + HDR_BYTES;
        o_result.payload_len   = (w_action == ACT_EMPTY) ? 16'd0 : w_len;
        o_result.new_boundary  = n_boundary;
        o_result.fetch_page    = page_after(n_boundary, i_cfg);
        o_result.err_total     = n_err_cnt;
        o_result.packet_total  = n_pkt_cnt;
        o_result.byte_total    = n_byte_cnt;
        o_result.overrun_total = n_ovr_cnt;
    end

    // empty ring leaves boundary and counters alone
    a_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (w_action == ACT_EMPTY) |=>
            $stable(r_boundary) && $stable(r_err_cnt) && $stable(r_pkt_cnt)
            && $stable(r_byte_cnt) && $stable(r_ovr_cnt))
        else $error("empty ring changed unload state");

    // the error count moves by at most one per transfer
    a_err_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> (r_err_cnt == $past(r_err_cnt)) || (r_err_cnt == $past(r_err_cnt) + 32'd1))
        else $error("error count jumped");

    // accepted frames always carry a legal length
    a_accept_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (w_action == ACT_ACCEPT) |->
            (w_len >= MIN_FRAME_LEN) && (w_len <= MAX_FRAME_LEN))
        else $error("accepted frame with bad length");

endmodule

### sv/rx_ring_frame_checker.sv
// ----------------------------------------------------------------------------
// rx_ring_frame_checker
// Receive ring unloader: checks one frame header per transfer and keeps the
// boundary page and the receive statistics.
// ----------------------------------------------------------------------------
// path: a header passes the input register, then the result register; the
//   step between them waits while the result register is stalled
// throughput: one header per cycle while the result is not stalled; the boundary
//   and counter update between the input register and the result register is combinational
// reset: boundary goes to stop page minus one, counters to zero, ring
//   registers to their defaults; no clearing pass
module rx_ring_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrfc_cfg_if.sink    i_cfg,
    rrfc_in_if.sink     i_rx,
    rrfc_out_if.source  o_res
);
    import rrfc_pkg::*;

    t_cfg      w_cfg;
    t_rx_item  r_in;
    logic      r_in_valid;
    t_result   w_result;
    t_result   r_out;
    logic      r_out_valid;
    logic      w_step;
    logic      w_take;

    rrfc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    assign w_step     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || w_step;
    assign w_take     = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.cur_page   <= i_rx.cur_page;
            r_in.hdr_status <= i_rx.hdr_status;
            r_in.hdr_next   <= i_rx.hdr_next;
            r_in.hdr_count  <= i_rx.hdr_count;
        end
    end

    rrfc_unload u_unload (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_item   (r_in),
        .i_step   (w_step),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.action        = r_out.action;
    assign o_res.frame_page    = r_out.frame_page;
    assign o_res.payload_addr  = r_out.payload_addr;
    assign o_res.payload_len   = r_out.payload_len;
    assign o_res.new_boundary  = r_out.new_boundary;
    assign o_res.fetch_page    = r_out.fetch_page;
    assign o_res.err_total     = r_out.err_total;
    assign o_res.packet_total  = r_out.packet_total;
    assign o_res.byte_total    = r_out.byte_total;
    assign o_res.overrun_total = r_out.overrun_total;

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |-> !w_step)
        else $error("result register overwritten while stalled");

    // every step lands in the result register
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("step lost");

    // a waiting header holds until it is stepped
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_step |=> r_in_valid && $stable(r_in))
        else $error("input register lost a waiting header");

endmodule
